// File: src/assert_macros.svh
// Assertion macros shared by the grid path search RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: src/gaps_pkg.sv
// Package for the grid path search: constants, types and shared functions.
// Depends on nothing.
package gaps_pkg;
  localparam int MaxCells = 65536;
  localparam int OpenCap = 1024;
  localparam int MaxPath = 256;
  localparam int CostScale = 1000;
  localparam int CellW = $clog2(MaxCells);
  localparam int OpenW = $clog2(OpenCap);
  localparam int PathW = $clog2(MaxPath);
  localparam logic [19:0] GMax = 20'hFFFFF;
  localparam logic [20:0] FMax = 21'h1FFFFF;
  localparam logic [19:0] StraightCost = 20'(CostScale);
  localparam logic [19:0] DiagCost = 20'(CostScale * 1414 / 1000);
  localparam logic [3:0] DirNone = 4'd8;

  localparam logic [2:0] StOk = 3'd0;
  localparam logic [2:0] StStartOff = 3'd1;
  localparam logic [2:0] StGoalOff = 3'd2;
  localparam logic [2:0] StOpenFull = 3'd3;
  localparam logic [2:0] StNoPath = 3'd4;
  localparam logic [2:0] StIndex = 3'd5;

  localparam logic [1:0] RegWidth = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegCell = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_DIV, S_CHECK, S_CLEAR, S_INIT, S_MIN_RD, S_MIN_WAIT, S_MIN_CMP,
    S_TAKE, S_SHIFT_RD, S_SHIFT_WR, S_CLOSE, S_NB_GEN, S_NB_CL_RD, S_NB_CHK,
    S_SCAN_RD, S_SCAN_CMP, S_NB_UPD, S_TR_RD, S_TR_WAIT, S_TR_STEP, S_READ_RD,
    S_READ_OUT, S_DONE
  } state_t;

  typedef struct packed {
    logic div_start;
    logic clear_step;
    logic init_open;
    logic min_begin;
    logic min_rd;
    logic min_cmp;
    logic take_rd;
    logic shift_rd;
    logic shift_wr;
    logic close_cur;
    logic nb_gen;
    logic nb_cl_rd;
    logic scan_begin;
    logic scan_rd;
    logic scan_cmp;
    logic nb_upd;
    logic tr_begin;
    logic tr_rd;
    logic tr_step;
    logic read_rd;
    logic fin;
    logic [2:0] fin_status;
    logic use_dp_status;
  } ctl_t;

  typedef struct packed {
    logic div_done;
    logic start_ok;
    logic goal_ok;
    logic clear_last;
    logic min_last;
    logic shift_last;
    logic at_goal;
    logic nb_valid;
    logic nb_last;
    logic nb_closed;
    logic scan_end;
    logic scan_hit;
    logic open_full;
    logic open_empty;
    logic tr_end;
    logic read_bad;
  } sts_t;

  function automatic logic [20:0] sat_f(input logic [21:0] s);
    sat_f = (s > {1'b0, FMax}) ? FMax : s[20:0];
  endfunction
endpackage

// File: src/gaps_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
module gaps_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: src/gaps_div.sv
// Restoring bit-serial divider, 16 bits by 8 bits, one quotient bit a cycle.
// Depends on nothing.
module gaps_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [7:0]  divisor,
  output logic [15:0] quotient,
  output logic        done
);
  logic [15:0] q_r, q_nxt;
  logic [8:0] rem_r, rem_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic [8:0] trial;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    trial = {rem_r[7:0], q_r[15]};
    if (start) begin
      q_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = 5'd16;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = trial - {1'b0, divisor};
        q_nxt = {q_r[14:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[14:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign quotient = q_r;
  assign done = !busy_r && !start;
endmodule

// File: src/gaps_ctrl.sv
// Controller state machine of the grid path search.
// Depends on gaps_pkg; drives the datapath through ctl_t and reads sts_t.
`include "assert_macros.svh"
module gaps_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_fire,
  input  logic            in_kind,
  input  logic            out_free,
  input  gaps_pkg::sts_t  sts,
  output gaps_pkg::ctl_t  ctl,
  output logic            busy
);
  gaps_pkg::state_t st_r, st_nxt;
  logic started_r, started_nxt;

  always_comb begin
    st_nxt = st_r;
    started_nxt = started_r;
    case (st_r)
      gaps_pkg::S_IDLE: begin
        if (in_fire) begin
          st_nxt = in_kind ? gaps_pkg::S_READ_RD : gaps_pkg::S_DIV;
          started_nxt = 1'b0;
        end
      end
      gaps_pkg::S_DIV: begin
        started_nxt = 1'b1;
        if (started_r && sts.div_done) begin
          st_nxt = gaps_pkg::S_CHECK;
        end
      end
      gaps_pkg::S_CHECK: begin
        if (!sts.start_ok || !sts.goal_ok) begin
          st_nxt = gaps_pkg::S_DONE;
        end else begin
          st_nxt = gaps_pkg::S_CLEAR;
        end
      end
      gaps_pkg::S_CLEAR: if (sts.clear_last) st_nxt = gaps_pkg::S_INIT;
      gaps_pkg::S_INIT: st_nxt = gaps_pkg::S_MIN_RD;
      gaps_pkg::S_MIN_RD: begin
        st_nxt = sts.open_empty ? gaps_pkg::S_DONE : gaps_pkg::S_MIN_WAIT;
      end
      gaps_pkg::S_MIN_WAIT: st_nxt = gaps_pkg::S_MIN_CMP;
      gaps_pkg::S_MIN_CMP: begin
        st_nxt = sts.min_last ? gaps_pkg::S_TAKE : gaps_pkg::S_MIN_WAIT;
      end
      gaps_pkg::S_TAKE: st_nxt = gaps_pkg::S_SHIFT_RD;
      gaps_pkg::S_SHIFT_RD: begin
        st_nxt = sts.shift_last ? gaps_pkg::S_CLOSE : gaps_pkg::S_SHIFT_WR;
      end
      gaps_pkg::S_SHIFT_WR: st_nxt = gaps_pkg::S_SHIFT_RD;
      gaps_pkg::S_CLOSE: begin
        st_nxt = sts.at_goal ? gaps_pkg::S_TR_RD : gaps_pkg::S_NB_GEN;
      end
      gaps_pkg::S_NB_GEN: st_nxt = gaps_pkg::S_NB_CL_RD;
      gaps_pkg::S_NB_CL_RD: st_nxt = gaps_pkg::S_NB_CHK;
      gaps_pkg::S_NB_CHK: begin
        if (!sts.nb_valid || sts.nb_closed) begin
          st_nxt = sts.nb_last ? gaps_pkg::S_MIN_RD : gaps_pkg::S_NB_GEN;
        end else begin
          st_nxt = gaps_pkg::S_SCAN_RD;
        end
      end
      gaps_pkg::S_SCAN_RD: begin
        st_nxt = sts.scan_end ? gaps_pkg::S_NB_UPD : gaps_pkg::S_SCAN_CMP;
      end
      gaps_pkg::S_SCAN_CMP: begin
        st_nxt = sts.scan_hit ? gaps_pkg::S_NB_UPD : gaps_pkg::S_SCAN_RD;
      end
      gaps_pkg::S_NB_UPD: begin
        if (sts.open_full) begin
          st_nxt = gaps_pkg::S_DONE;
        end else begin
          st_nxt = sts.nb_last ? gaps_pkg::S_MIN_RD : gaps_pkg::S_NB_GEN;
        end
      end
      gaps_pkg::S_TR_RD: st_nxt = gaps_pkg::S_TR_WAIT;
      gaps_pkg::S_TR_WAIT: st_nxt = gaps_pkg::S_TR_STEP;
      gaps_pkg::S_TR_STEP: st_nxt = sts.tr_end ? gaps_pkg::S_DONE : gaps_pkg::S_TR_RD;
      gaps_pkg::S_READ_RD: st_nxt = gaps_pkg::S_READ_OUT;
      gaps_pkg::S_READ_OUT: st_nxt = gaps_pkg::S_DONE;
      gaps_pkg::S_DONE: if (out_free) st_nxt = gaps_pkg::S_IDLE;
      default: st_nxt = gaps_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    case (st_r)
      gaps_pkg::S_DIV: ctl.div_start = !started_r;
      gaps_pkg::S_CHECK: begin
        if (!sts.start_ok) begin
          ctl.fin = 1'b1;
          ctl.fin_status = gaps_pkg::StStartOff;
        end else if (!sts.goal_ok) begin
          ctl.fin = 1'b1;
          ctl.fin_status = gaps_pkg::StGoalOff;
        end
      end
      gaps_pkg::S_CLEAR: ctl.clear_step = 1'b1;
      gaps_pkg::S_INIT: ctl.init_open = 1'b1;
      gaps_pkg::S_MIN_RD: begin
        ctl.min_begin = 1'b1;
        if (sts.open_empty) begin
          ctl.fin = 1'b1;
          ctl.fin_status = gaps_pkg::StNoPath;
        end
      end
      gaps_pkg::S_MIN_WAIT: ctl.min_rd = 1'b1;
      gaps_pkg::S_MIN_CMP: ctl.min_cmp = 1'b1;
      gaps_pkg::S_TAKE: ctl.take_rd = 1'b1;
      gaps_pkg::S_SHIFT_RD: ctl.shift_rd = 1'b1;
      gaps_pkg::S_SHIFT_WR: ctl.shift_wr = 1'b1;
      gaps_pkg::S_CLOSE: ctl.close_cur = 1'b1;
      gaps_pkg::S_NB_GEN: ctl.nb_gen = 1'b1;
      gaps_pkg::S_NB_CL_RD: ctl.nb_cl_rd = 1'b1;
      gaps_pkg::S_NB_CHK: ctl.scan_begin = 1'b1;
      gaps_pkg::S_SCAN_RD: ctl.scan_rd = 1'b1;
      gaps_pkg::S_SCAN_CMP: ctl.scan_cmp = 1'b1;
      gaps_pkg::S_NB_UPD: begin
        ctl.nb_upd = 1'b1;
        if (sts.open_full) begin
          ctl.fin = 1'b1;
          ctl.fin_status = gaps_pkg::StOpenFull;
        end
      end
      gaps_pkg::S_TR_RD: ctl.tr_rd = 1'b1;
      gaps_pkg::S_TR_STEP: begin
        ctl.tr_step = 1'b1;
        if (sts.tr_end) begin
          ctl.fin = 1'b1;
          ctl.fin_status = gaps_pkg::StOk;
        end
      end
      gaps_pkg::S_READ_RD: ctl.read_rd = 1'b1;
      gaps_pkg::S_READ_OUT: begin
        ctl.fin = 1'b1;
        ctl.use_dp_status = 1'b1;
      end
      default: ctl = '0;
    endcase
    ctl.tr_begin = (st_r == gaps_pkg::S_CLOSE) && sts.at_goal;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= gaps_pkg::S_IDLE;
      started_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      started_r <= started_nxt;
    end
  end

  assign busy = (st_r != gaps_pkg::S_IDLE);

  `ASSERT_NEXT(a_idle_accept, clk, rst_n, in_fire, st_r != gaps_pkg::S_IDLE)
  `ASSERT_NEXT(a_fin_done, clk, rst_n, ctl.fin, st_r == gaps_pkg::S_DONE)
  `ASSERT_IMPL(a_fin_once, clk, rst_n, !(ctl.fin && st_r == gaps_pkg::S_DONE))
endmodule

// File: src/gaps_dp.sv
// Datapath of the grid path search: divider, open list, closed map, parents, path.
// Depends on gaps_pkg, gaps_ram and gaps_div.
module gaps_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  gaps_pkg::ctl_t ctl,
  output gaps_pkg::sts_t sts,
  input  logic           in_fire,
  input  logic [15:0]    in_start_x,
  input  logic [15:0]    in_start_y,
  input  logic [15:0]    in_goal_x,
  input  logic [15:0]    in_goal_y,
  input  logic [7:0]     in_waypoint_index,
  input  logic [8:0]     grid_w,
  input  logic [8:0]     grid_h,
  input  logic [7:0]     cell_sz,
  output logic [2:0]     res_status,
  output logic [8:0]     res_len,
  output logic [15:0]    res_x,
  output logic [15:0]    res_y
);
  localparam int CW = gaps_pkg::CellW;
  localparam int OW = gaps_pkg::OpenW;
  localparam int PW = gaps_pkg::PathW;
  localparam int EW = CW + 20 + 21 + 4;

  logic [8:0] w_eff, h_eff;
  logic [7:0] cs_eff;
  assign w_eff = (grid_w > 9'd256) ? 9'd256 : grid_w;
  assign h_eff = (grid_h > 9'd256) ? 9'd256 : grid_h;
  assign cs_eff = (cell_sz == 8'd0) ? 8'd1 : cell_sz;

  // Pixel inputs and division sequencing.
  logic [15:0] pix_r [4];
  logic [15:0] coord_r [4];
  logic [1:0] dsel_r;
  logic [7:0] ridx_r;
  logic dstart;
  logic [15:0] dq;
  logic ddone;
  logic dbusy_r;

  gaps_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart), .dividend(pix_r[dsel_r]),
    .divisor(cs_eff), .quotient(dq), .done(ddone)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dsel_r <= '0;
      dbusy_r <= 1'b0;
    end else if (ctl.div_start) begin
      dsel_r <= '0;
      dbusy_r <= 1'b1;
    end else if (dbusy_r && ddone) begin
      dsel_r <= dsel_r + 2'd1;
      if (dsel_r == 2'd3) dbusy_r <= 1'b0;
    end
    if (in_fire) begin
      pix_r[0] <= in_start_x;
      pix_r[1] <= in_start_y;
      pix_r[2] <= in_goal_x;
      pix_r[3] <= in_goal_y;
      ridx_r <= in_waypoint_index;
    end
    if (dbusy_r && ddone && !dstart) coord_r[dsel_r] <= dq;
  end
  logic dpend_r;
  always_ff @(posedge clk) begin
    if (!rst_n) dpend_r <= 1'b0;
    else dpend_r <= ctl.div_start || (dbusy_r && ddone && dsel_r != 2'd3);
  end
  assign dstart = dpend_r;

  // Grid membership of start and goal.
  logic [16:0] sidx, gidx;
  logic s_in, g_in;
  assign sidx = 17'(coord_r[1]) * 17'(w_eff) + 17'(coord_r[0]);
  assign gidx = 17'(coord_r[3]) * 17'(w_eff) + 17'(coord_r[2]);
  assign s_in = (coord_r[0] < 16'(w_eff)) && (coord_r[1] < 16'(h_eff))
                && (sidx < 17'(gaps_pkg::MaxCells));
  assign g_in = (coord_r[2] < 16'(w_eff)) && (coord_r[3] < 16'(h_eff))
                && (gidx < 17'(gaps_pkg::MaxCells));

  // Search registers.
  logic [7:0] gx_r, gy_r;
  logic [CW-1:0] goal_r;
  logic [OW:0] cnt_r;
  logic [OW:0] ptr_r;
  logic [OW-1:0] best_r;
  logic [20:0] bestf_r;
  logic [CW:0] clr_r;
  logic [CW-1:0] cur_r;
  logic [7:0] cx_r, cy_r;
  logic [19:0] curg_r;
  logic [3:0] curdir_r;
  logic [3:0] nbd_r;
  logic [8:0] nx_r, ny_r;
  logic nbv_r;
  logic [CW-1:0] nbc_r;
  logic [19:0] nbg_r;
  logic [20:0] nbf_r;
  logic hit_r;
  logic [OW-1:0] hitp_r;
  logic [20:0] hitf_r;
  logic [8:0] len_r;
  logic [PW:0] n_r;
  logic [7:0] tx_r, ty_r;
  logic [2:0] st_r;
  logic [15:0] ox_r, oy_r;
  logic [2:0] dpst_r;
  logic [15:0] mx, my;

  // Open list memory (one entry = cell, g, f, dir).
  logic oe_we;
  logic [OW-1:0] oe_wa, oe_ra;
  logic [EW-1:0] oe_wd, oe_rd;
  gaps_ram #(.Width(EW), .Depth(gaps_pkg::OpenCap)) u_open (
    .clk(clk), .we(oe_we), .waddr(oe_wa), .wdata(oe_wd), .raddr(oe_ra), .rdata(oe_rd)
  );
  logic [CW-1:0] rd_cell;
  logic [19:0] rd_g;
  logic [20:0] rd_f;
  logic [3:0] rd_dir;
  assign {rd_cell, rd_g, rd_f, rd_dir} = oe_rd;

  // Closed map and parent directions, addressed by {y, x}.
  logic cm_we, cm_wd, cm_rd;
  logic [CW-1:0] cm_wa, cm_ra;
  gaps_ram #(.Width(1), .Depth(gaps_pkg::MaxCells)) u_closed (
    .clk(clk), .we(cm_we), .waddr(cm_wa), .wdata(cm_wd), .raddr(cm_ra), .rdata(cm_rd)
  );
  logic pd_we;
  logic [CW-1:0] pd_wa, pd_ra;
  logic [3:0] pd_rd;
  gaps_ram #(.Width(4), .Depth(gaps_pkg::MaxCells)) u_parent (
    .clk(clk), .we(pd_we), .waddr(pd_wa), .wdata(curdir_r), .raddr(pd_ra), .rdata(pd_rd)
  );
  logic ps_we;
  logic [PW-1:0] ps_wa, ps_ra;
  logic [15:0] ps_wd, ps_rd;
  gaps_ram #(.Width(16), .Depth(gaps_pkg::MaxPath)) u_path (
    .clk(clk), .we(ps_we), .waddr(ps_wa), .wdata(ps_wd), .raddr(ps_ra), .rdata(ps_rd)
  );

  // Neighbour step offsets.
  logic signed [1:0] sdx, sdy;
  always_comb begin
    case (nbd_r[2:0])
      3'd0: begin sdx = 2'sd1; sdy = 2'sd0; end
      3'd1: begin sdx = -2'sd1; sdy = 2'sd0; end
      3'd2: begin sdx = 2'sd0; sdy = 2'sd1; end
      3'd3: begin sdx = 2'sd0; sdy = -2'sd1; end
      3'd4: begin sdx = 2'sd1; sdy = 2'sd1; end
      3'd5: begin sdx = 2'sd1; sdy = -2'sd1; end
      3'd6: begin sdx = -2'sd1; sdy = 2'sd1; end
      default: begin sdx = -2'sd1; sdy = -2'sd1; end
    endcase
  end
  logic signed [1:0] tdx, tdy;
  always_comb begin
    case (pd_rd[2:0])
      3'd0: begin tdx = 2'sd1; tdy = 2'sd0; end
      3'd1: begin tdx = -2'sd1; tdy = 2'sd0; end
      3'd2: begin tdx = 2'sd0; tdy = 2'sd1; end
      3'd3: begin tdx = 2'sd0; tdy = -2'sd1; end
      3'd4: begin tdx = 2'sd1; tdy = 2'sd1; end
      3'd5: begin tdx = 2'sd1; tdy = -2'sd1; end
      3'd6: begin tdx = -2'sd1; tdy = 2'sd1; end
      default: begin tdx = -2'sd1; tdy = -2'sd1; end
    endcase
  end

  // Neighbour candidate (combinational from cur and direction).
  logic [9:0] ncx, ncy;
  assign ncx = {2'b0, cx_r} + {{8{sdx[1]}}, sdx};
  assign ncy = {2'b0, cy_r} + {{8{sdy[1]}}, sdy};
  logic [16:0] nidx;
  assign nidx = 17'(ny_r) * 17'(w_eff) + 17'(nx_r);
  logic ninb;
  assign ninb = nbv_r && (nx_r < w_eff) && (ny_r < h_eff)
                && (nidx < 17'(gaps_pkg::MaxCells));
  logic [8:0] adx, ady;
  assign adx = (nx_r >= {1'b0, gx_r}) ? nx_r - {1'b0, gx_r} : {1'b0, gx_r} - nx_r;
  assign ady = (ny_r >= {1'b0, gy_r}) ? ny_r - {1'b0, gy_r} : {1'b0, gy_r} - ny_r;
  logic [20:0] heur_v;
  assign heur_v = 21'({1'b0, adx} + {1'b0, ady}) * 21'(gaps_pkg::CostScale);
  logic [20:0] gsum;
  assign gsum = {1'b0, curg_r} + {1'b0, (nbd_r < 4'd4) ? gaps_pkg::StraightCost
                                                        : gaps_pkg::DiagCost};
  logic [19:0] gsat;
  assign gsat = (gsum > {1'b0, gaps_pkg::GMax}) ? gaps_pkg::GMax : gsum[19:0];

  // Start heuristic.
  logic [15:0] sdxa, sdya;
  assign sdxa = (coord_r[0] >= coord_r[2]) ? coord_r[0] - coord_r[2] : coord_r[2] - coord_r[0];
  assign sdya = (coord_r[1] >= coord_r[3]) ? coord_r[1] - coord_r[3] : coord_r[3] - coord_r[1];
  logic [20:0] sh;
  assign sh = 21'(sdxa + sdya) * 21'(gaps_pkg::CostScale);

  // Trace-back next cell.
  logic [8:0] pxn, pyn;
  assign pxn = {1'b0, tx_r} - {{7{tdx[1]}}, tdx};
  assign pyn = {1'b0, ty_r} - {{7{tdy[1]}}, tdy};
  logic [16:0] pidx;
  assign pidx = 17'(pyn) * 17'(w_eff) + 17'(pxn);

  // The trace loop ends on the step after the last stored waypoint.
  logic tr_stop;
  assign tr_stop = pd_rd >= gaps_pkg::DirNone || pxn >= w_eff || pyn >= h_eff
                   || pidx >= 17'(gaps_pkg::MaxCells)
                   || n_r + 1'b1 >= (PW+1)'(gaps_pkg::MaxPath);

  assign mx = 16'(ps_rd[7:0]) * 16'(cs_eff);
  assign my = 16'(ps_rd[15:8]) * 16'(cs_eff);

  // Memory ports.
  always_comb begin
    oe_we = 1'b0;
    oe_wa = '0;
    oe_wd = '0;
    oe_ra = ptr_r[OW-1:0];
    cm_we = 1'b0;
    cm_wa = clr_r[CW-1:0];
    cm_wd = 1'b0;
    cm_ra = {ny_r[7:0], nx_r[7:0]};
    pd_we = 1'b0;
    pd_wa = cur_r;
    pd_ra = {ty_r, tx_r};
    ps_we = 1'b0;
    ps_wa = n_r[PW-1:0];
    ps_wd = {ty_r, tx_r};
    ps_ra = ridx_r[PW-1:0];
    if (ctl.clear_step) begin
      cm_we = 1'b1;
    end
    if (ctl.init_open) begin
      oe_we = 1'b1;
      oe_wa = '0;
      oe_wd = {coord_r[1][7:0], coord_r[0][7:0], 20'd0, gaps_pkg::sat_f({1'b0, sh}),
               gaps_pkg::DirNone};
    end
    if (ctl.take_rd) oe_ra = best_r;
    if (ctl.shift_wr) begin
      oe_we = 1'b1;
      oe_wa = OW'(ptr_r - 1'b1);
      oe_wd = oe_rd;
    end
    if (ctl.close_cur) begin
      cm_we = 1'b1;
      cm_wa = cur_r;
      cm_wd = 1'b1;
      pd_we = 1'b1;
    end
    if (ctl.nb_upd && !sts.open_full) begin
      if (hit_r) begin
        if (nbf_r < hitf_r) begin
          oe_we = 1'b1;
          oe_wa = hitp_r;
          oe_wd = {nbc_r, nbg_r, nbf_r, nbd_r};
        end
      end else begin
        oe_we = 1'b1;
        oe_wa = cnt_r[OW-1:0];
        oe_wd = {nbc_r, nbg_r, nbf_r, nbd_r};
      end
    end
    if (ctl.tr_rd && n_r < (PW+1)'(gaps_pkg::MaxPath)) begin
      ps_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      len_r <= '0;
      st_r <= gaps_pkg::StOk;
      clr_r <= '0;
    end else begin
      if (in_fire) begin
        clr_r <= '0;
      end
      if (ctl.clear_step) clr_r <= clr_r + 1'b1;
      if (ctl.fin && !ctl.use_dp_status) st_r <= ctl.fin_status;
      if (ctl.fin && ctl.use_dp_status) st_r <= dpst_r;
      if (ctl.div_start) len_r <= '0;
      if (ctl.init_open) cnt_r <= (OW+1)'(1);
      if (ctl.take_rd) cnt_r <= cnt_r - 1'b1;
      if (ctl.nb_upd && !hit_r && !sts.open_full) cnt_r <= cnt_r + 1'b1;
      if (ctl.tr_step && tr_stop) len_r <= 9'(n_r + 1'b1);
    end
    if (ctl.init_open) begin
      gx_r <= coord_r[2][7:0];
      gy_r <= coord_r[3][7:0];
      goal_r <= {coord_r[3][7:0], coord_r[2][7:0]};
    end
    if (ctl.min_begin) begin
      ptr_r <= '0;
      best_r <= '0;
      bestf_r <= gaps_pkg::FMax;
    end
    if (ctl.min_rd) ptr_r <= ptr_r + 1'b1;
    if (ctl.min_cmp) begin
      if (ptr_r == (OW+1)'(1) || rd_f < bestf_r) begin
        best_r <= OW'(ptr_r - 1'b1);
        bestf_r <= rd_f;
      end
    end
    if (ctl.take_rd) ptr_r <= {1'b0, best_r} + 1'b1;
    if (ctl.shift_rd) begin
      if (ptr_r == {1'b0, best_r} + 1'b1) begin
        cur_r <= rd_cell;
        curg_r <= rd_g;
        curdir_r <= rd_dir;
        cx_r <= rd_cell[7:0];
        cy_r <= rd_cell[15:8];
      end
    end
    if (ctl.shift_wr) ptr_r <= ptr_r + 1'b1;
    if (ctl.close_cur) nbd_r <= 4'd0;
    if (ctl.nb_gen) begin
      nx_r <= ncx[8:0];
      ny_r <= ncy[8:0];
      nbv_r <= !ncx[9] && !ncy[9];
    end
    if (ctl.nb_cl_rd) begin
      nbc_r <= {ny_r[7:0], nx_r[7:0]};
      nbg_r <= gsat;
      nbf_r <= gaps_pkg::sat_f({1'b0, gsat} + {1'b0, heur_v});
    end
    if (ctl.scan_begin) begin
      ptr_r <= '0;
      hit_r <= 1'b0;
      if (!ninb || cm_rd) nbd_r <= nbd_r + 4'd1;
    end
    if (ctl.scan_rd && !sts.scan_end) ptr_r <= ptr_r + 1'b1;
    if (ctl.scan_cmp && rd_cell == nbc_r) begin
      hit_r <= 1'b1;
      hitp_r <= OW'(ptr_r - 1'b1);
      hitf_r <= rd_f;
    end
    if (ctl.nb_upd) nbd_r <= nbd_r + 4'd1;
    if (ctl.tr_begin) begin
      n_r <= '0;
      tx_r <= cx_r;
      ty_r <= cy_r;
    end
    if (ctl.tr_step) begin
      n_r <= n_r + 1'b1;
      tx_r <= pxn[7:0];
      ty_r <= pyn[7:0];
    end
    if (ctl.read_rd) begin
      dpst_r <= ({1'b0, ridx_r} >= len_r) ? gaps_pkg::StIndex : gaps_pkg::StOk;
    end
    if (ctl.fin) begin
      ox_r <= (ctl.use_dp_status && dpst_r == gaps_pkg::StOk) ? mx : '0;
      oy_r <= (ctl.use_dp_status && dpst_r == gaps_pkg::StOk) ? my : '0;
    end
  end

  always_comb begin
    sts = '0;
    sts.div_done = !dbusy_r && !dpend_r;
    sts.start_ok = s_in;
    sts.goal_ok = g_in;
    sts.clear_last = clr_r == (CW+1)'(gaps_pkg::MaxCells - 1);
    sts.min_last = ptr_r == cnt_r;
    sts.shift_last = ptr_r >= cnt_r + 1'b1;
    sts.at_goal = cur_r == goal_r;
    sts.nb_valid = ninb;
    sts.nb_last = nbd_r == 4'd7;
    sts.nb_closed = cm_rd;
    sts.scan_end = ptr_r >= cnt_r;
    sts.scan_hit = rd_cell == nbc_r;
    sts.open_full = !hit_r && cnt_r >= (OW+1)'(gaps_pkg::OpenCap);
    sts.open_empty = cnt_r == '0;
    sts.tr_end = tr_stop;
    sts.read_bad = dpst_r != gaps_pkg::StOk;
  end

  assign res_status = st_r;
  assign res_len = len_r;
  assign res_x = ox_r;
  assign res_y = oy_r;
endmodule

// File: src/grid_astar_path_search.sv
// Top level of the grid path search: valid/ready channels and config port.
// Depends on gaps_pkg, gaps_ctrl and gaps_dp.
//
// One item is taken on the input channel when in_valid and in_ready are high.
// A search item (kind 0) divides the four pixel positions into cells with a
// bit-serial divider, clears the 65536-entry closed map in one pass, then
// runs A*. Each expansion scans the open list in memory to find the cheapest
// entry, shifts the tail down one entry at a time, and scans the list again
// for each of the eight neighbours that lies in the grid and is not yet
// closed, so the length of a search is set by the clearing pass and the open
// list memory port.
// A read item (kind 1) passes the READ_RD and READ_OUT states before its result
// beat, and the next item can be taken after that beat leaves on out_ready.
// Each item yields one result beat held on the out_ ports until out_ready;
// the block takes no new item until that beat leaves.
// Reset restores the default grid of 192 by 128 cells of 5 pixels and
// empties the stored path. Configuration should be written only while the
// block is idle.
`include "assert_macros.svh"
module grid_astar_path_search (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [15:0] in_start_x,
  input  logic [15:0] in_start_y,
  input  logic [15:0] in_goal_x,
  input  logic [15:0] in_goal_y,
  input  logic [7:0]  in_waypoint_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [8:0]  out_path_length,
  output logic [15:0] out_waypoint_x,
  output logic [15:0] out_waypoint_y,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);
  logic [8:0] gw_r, gh_r;
  logic [7:0] cs_r;
  gaps_pkg::ctl_t ctl;
  gaps_pkg::sts_t sts;
  logic busy, in_fire, ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r <= 9'd192;
      gh_r <= 9'd128;
      cs_r <= 8'd5;
    end else if (cfg_we) begin
      case (cfg_index)
        gaps_pkg::RegWidth: gw_r <= cfg_data;
        gaps_pkg::RegHeight: gh_r <= cfg_data;
        gaps_pkg::RegCell: cs_r <= cfg_data[7:0];
        default: gw_r <= gw_r;
      endcase
    end
  end

  assign in_ready = !busy;
  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (ctl.fin) ov_r <= 1'b1;
    else if (out_ready) ov_r <= 1'b0;
  end
  assign out_valid = ov_r;

  gaps_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_kind(in_kind),
    .out_free(!ov_r || out_ready), .sts(sts), .ctl(ctl), .busy(busy)
  );

  gaps_dp u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts), .in_fire(in_fire),
    .in_start_x(in_start_x), .in_start_y(in_start_y), .in_goal_x(in_goal_x),
    .in_goal_y(in_goal_y), .in_waypoint_index(in_waypoint_index),
    .grid_w(gw_r), .grid_h(gh_r), .cell_sz(cs_r),
    .res_status(out_status), .res_len(out_path_length),
    .res_x(out_waypoint_x), .res_y(out_waypoint_y)
  );

  `ASSERT_IMPL(a_no_accept_busy, clk, rst_n, !(in_fire && ov_r))
  `ASSERT_NEXT(a_fin_valid, clk, rst_n, ctl.fin, out_valid)
  `ASSERT_IMPL(a_status_range, clk, rst_n, !out_valid || out_status <= gaps_pkg::StIndex)
endmodule
